FILE: hw/rtl/qou_pkg.sv
// Shared types, codes and term tables for the quaternion orientation unit.
// Used by the lane, square root and top level files; depends on nothing.
package qou_pkg;

   localparam int RAD_W  = 64;
   localparam int ROOT_W = RAD_W / 2;
   localparam int KIND_W = 3;
   localparam int EPS_W  = 17;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MUL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ROTV   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADDV   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NORM   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ROTINV = 3'd5;

   localparam logic [2:0] PASS_HQO = 3'd0;
   localparam logic [2:0] PASS_HPQ = 3'd1;
   localparam logic [2:0] PASS_SCL = 3'd2;
   localparam logic [2:0] PASS_SQ  = 3'd3;
   localparam logic [2:0] PASS_TV  = 3'd4;
   localparam logic [2:0] PASS_RT  = 3'd5;

   typedef struct packed {
      logic valid;
      logic first;
      logic neg;
   } lane_ctl_type;

   // Hamilton product r = a * b: lane is the result component, bit k of the
   // sign mask marks a subtracted term.
   localparam logic [1:0] HAM_A [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}};
   localparam logic [1:0] HAM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd2, 2'd1}};
   localparam logic [3:0] HAM_N [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

   // Conjugate times vector, three terms per lane.
   localparam logic [1:0] TV_A [4][4] = '{
      '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd0, 2'd2, 2'd3, 2'd0},
      '{2'd0, 2'd3, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd0}};
   localparam logic [1:0] TV_B [4][4] = '{
      '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd2, 2'd0},
      '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0}};
   localparam logic [3:0] TV_N [4] = '{4'b0000, 4'b0010, 4'b0010, 4'b0010};

   // Vector part of t * q; the first operand of term k is t component k.
   localparam logic [1:0] RT_B [4][4] = '{
      '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}};
   localparam logic [3:0] RT_N [4] = '{4'b0000, 4'b1000, 4'b0010, 4'b0100};

endpackage

FILE: hw/rtl/quaternion_orientation_unit_core.sv
// Top level of the quaternion orientation unit: sequencer, four lanes,
// merge stage, square root and dividers. Depends on qou_pkg and all units.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | kind, operand w/x/y/z, scale
//   rsp     | out       | rsp_valid/ready    | quat w/x/y/z, rotated x/y/z
//   csr     | in        | csr_wr_en          | epsilon threshold, 17 bits
//
// Load writes the quaternion directly; the other kinds run product passes
// through the lanes, and normalize may then run the square root and dividers.
// Each lane runs one product per cycle while terms issue. One transaction
// is worked on at a time; a new one is taken while the previous response
// waits. Reset is synchronous and restores identity.
module quaternion_orientation_unit_core #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [qou_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [WORD_WIDTH-1:0]       req_operand_w,
   input  logic signed [WORD_WIDTH-1:0]       req_operand_x,
   input  logic signed [WORD_WIDTH-1:0]       req_operand_y,
   input  logic signed [WORD_WIDTH-1:0]       req_operand_z,
   input  logic signed [WORD_WIDTH-1:0]       req_scale,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [WORD_WIDTH-1:0]       rsp_quat_w,
   output logic signed [WORD_WIDTH-1:0]       rsp_quat_x,
   output logic signed [WORD_WIDTH-1:0]       rsp_quat_y,
   output logic signed [WORD_WIDTH-1:0]       rsp_quat_z,
   output logic signed [WORD_WIDTH-1:0]       rsp_rotated_x,
   output logic signed [WORD_WIDTH-1:0]       rsp_rotated_y,
   output logic signed [WORD_WIDTH-1:0]       rsp_rotated_z,
   input  logic                               csr_wr_en,
   input  logic [qou_pkg::EPS_W-1:0]          csr_wr_data
);
   import qou_pkg::*;

   localparam int W     = WORD_WIDTH;
   localparam int ACC_W = 2 * W + 3;
   localparam int DVD_W = W + FRAC_BITS;
   localparam int EXT_W = (ACC_W > RAD_W) ? ACC_W : RAD_W;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) << FRAC_BITS;
   localparam logic [RAD_W-1:0] CAP  = {RAD_W{1'b1}} >> FRAC_BITS;
   localparam logic [DVD_W-1:0] QPOS = {{(FRAC_BITS+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [DVD_W-1:0] QNEG = QPOS + 1'b1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_SQRT  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   function automatic logic signed [W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > ACC_MAX) begin
         r = ACC_MAX;
      end else if (v < ACC_MIN) begin
         r = ACC_MIN;
      end
      return r[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] div_word(input logic neg,
                                                    input logic [DVD_W-1:0] quo);
      logic signed [W-1:0] r;
      if (!neg) begin
         r = (quo > QPOS) ? QPOS[W-1:0] : quo[W-1:0];
      end else begin
         r = (quo > QNEG) ? QNEG[W-1:0] : -quo[W-1:0];
      end
      return r;
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [2:0]            pass_ff, pass_in;
   logic [1:0]            k_ff, k_in;
   logic [EPS_W-1:0]      eps_ff;
   logic signed [W-1:0]   q_ff [4];
   logic signed [W-1:0]   q_in [4];
   logic signed [W-1:0]   op_ff [4];
   logic signed [W-1:0]   op_in [4];
   logic signed [W-1:0]   aux_ff [4];
   logic signed [W-1:0]   aux_in [4];
   logic signed [W-1:0]   rot_ff [3];
   logic signed [W-1:0]   rot_in [3];
   logic signed [W-1:0]   scale_ff, scale_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]   out_q_ff [4];
   logic signed [W-1:0]   out_rot_ff [3];
   logic                  out_load;

   lane_ctl_type            lane_ctl [4];
   logic signed [W-1:0]     lane_a [4];
   logic signed [W-1:0]     lane_b [4];
   logic signed [ACC_W-1:0] lane_acc [4];

   logic [EXT_W-1:0]      d_ext;
   logic                  d_small;
   logic [RAD_W-1:0]      radicand;
   logic                  sqrt_start;
   logic                  sqrt_done;
   logic [ROOT_W-1:0]     root;
   logic                  div_start;
   logic                  div_done [4];
   logic [DVD_W-1:0]      dividend [4];
   logic [DVD_W-1:0]      quotient [4];
   logic                  q_neg [4];

   for (genvar i = 0; i < 4; i++) begin : g_lane
      always_comb begin
         lane_a[i] = '0;
         lane_b[i] = '0;
         lane_ctl[i].neg = 1'b0;
         unique case (pass_ff)
            PASS_HQO: begin
               lane_a[i] = q_ff[HAM_A[i][k_ff]];
               lane_b[i] = op_ff[HAM_B[i][k_ff]];
               lane_ctl[i].neg = HAM_N[i][k_ff];
            end
            PASS_HPQ: begin
               lane_a[i] = aux_ff[HAM_A[i][k_ff]];
               lane_b[i] = q_ff[HAM_B[i][k_ff]];
               lane_ctl[i].neg = HAM_N[i][k_ff];
            end
            PASS_SCL: begin
               if (i != 0 && k_ff == 2'd0) begin
                  lane_a[i] = op_ff[i];
                  lane_b[i] = scale_ff;
               end
            end
            PASS_SQ: begin
               if (i == 0) begin
                  lane_a[i] = q_ff[k_ff];
                  lane_b[i] = q_ff[k_ff];
               end
            end
            PASS_TV: begin
               if (k_ff != 2'd3) begin
                  lane_a[i] = q_ff[TV_A[i][k_ff]];
                  lane_b[i] = op_ff[TV_B[i][k_ff]];
                  lane_ctl[i].neg = TV_N[i][k_ff];
               end
            end
            PASS_RT: begin
               if (i != 0) begin
                  lane_a[i] = aux_ff[k_ff];
                  lane_b[i] = q_ff[RT_B[i][k_ff]];
                  lane_ctl[i].neg = RT_N[i][k_ff];
               end
            end
            default: begin
            end
         endcase
         lane_ctl[i].valid = (state_ff == S_ISSUE);
         lane_ctl[i].first = (k_ff == 2'd0);
      end

      qou_lane #(
         .WORD_WIDTH (W),
         .FRAC_BITS  (FRAC_BITS),
         .ACC_WIDTH  (ACC_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (lane_ctl[i]),
         .a_in    (lane_a[i]),
         .b_in    (lane_b[i]),
         .acc_out (lane_acc[i])
      );

      always_comb begin
         q_neg[i]    = q_ff[i][W-1];
         dividend[i] = {(q_neg[i] ? -q_ff[i] : q_ff[i]), {FRAC_BITS{1'b0}}};
      end

      qou_div #(
         .DVD_WIDTH (DVD_W),
         .DSR_WIDTH (ROOT_W)
      ) u_div (
         .clock        (clock),
         .reset        (reset),
         .start_in     (div_start),
         .dividend_in  (dividend[i]),
         .divisor_in   (root),
         .done_out     (div_done[i]),
         .quotient_out (quotient[i])
      );
   end

   qou_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .start_in    (sqrt_start),
      .radicand_in (radicand),
      .done_out    (sqrt_done),
      .root_out    (root)
   );

   always_comb begin
      d_ext    = EXT_W'($unsigned(lane_acc[0]));
      d_small  = (d_ext == '0) || (d_ext < EXT_W'(eps_ff));
      radicand = ((d_ext > EXT_W'(CAP)) ? CAP : d_ext[RAD_W-1:0]) << FRAC_BITS;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign sqrt_start = (state_ff == S_MERGE) && (pass_ff == PASS_SQ) && !d_small;
   assign div_start  = (state_ff == S_SQRT) && sqrt_done && (root != '0);

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      k_in     = k_ff;
      q_in     = q_ff;
      op_in    = op_ff;
      aux_in   = aux_ff;
      rot_in   = rot_ff;
      scale_in = scale_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in[0] = (req_kind == KIND_ROTV) ? '0 : req_operand_w;
               op_in[1] = req_operand_x;
               op_in[2] = req_operand_y;
               op_in[3] = req_operand_z;
               scale_in = req_scale;
               rot_in   = '{default: '0};
               k_in     = 2'd0;
               state_in = S_ISSUE;
               unique case (req_kind)
                  KIND_LOAD: begin
                     q_in[0]  = req_operand_w;
                     q_in[1]  = req_operand_x;
                     q_in[2]  = req_operand_y;
                     q_in[3]  = req_operand_z;
                     state_in = S_DONE;
                  end
                  KIND_MUL, KIND_ROTV: pass_in = PASS_HQO;
                  KIND_ADDV:           pass_in = PASS_SCL;
                  KIND_NORM:           pass_in = PASS_SQ;
                  KIND_ROTINV:         pass_in = PASS_TV;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_ISSUE: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_MERGE;
         S_MERGE: begin
            state_in = S_DONE;
            k_in     = 2'd0;
            unique case (pass_ff)
               PASS_HQO: begin
                  for (int i = 0; i < 4; i++) begin
                     q_in[i] = sat_word(lane_acc[i]);
                  end
               end
               PASS_SCL: begin
                  aux_in[0] = '0;
                  for (int i = 1; i < 4; i++) begin
                     aux_in[i] = sat_word(lane_acc[i]);
                  end
                  pass_in  = PASS_HPQ;
                  state_in = S_ISSUE;
               end
               PASS_HPQ: begin
                  for (int i = 0; i < 4; i++) begin
                     q_in[i] = sat_word(ACC_W'(q_ff[i]) + ACC_W'(sat_word(lane_acc[i]) >>> 1));
                  end
               end
               PASS_SQ: begin
                  if (d_small) begin
                     q_in[0] = sat_word(ACC_ONE);
                  end else begin
                     state_in = S_SQRT;
                  end
               end
               PASS_TV: begin
                  for (int i = 0; i < 4; i++) begin
                     aux_in[i] = sat_word(lane_acc[i]);
                  end
                  pass_in  = PASS_RT;
                  state_in = S_ISSUE;
               end
               PASS_RT: begin
                  for (int i = 0; i < 3; i++) begin
                     rot_in[i] = sat_word(lane_acc[i+1]);
                  end
               end
               default: begin
               end
            endcase
         end
         S_SQRT: begin
            if (sqrt_done) begin
               if (root == '0) begin
                  q_in[0]  = sat_word(ACC_ONE);
                  state_in = S_DONE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done[0]) begin
               for (int i = 0; i < 4; i++) begin
                  q_in[i] = div_word(q_neg[i], quotient[i]);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_HQO;
         k_ff         <= 2'd0;
         eps_ff       <= EPS_W'(1);
         rsp_valid_ff <= 1'b0;
         q_ff[0]      <= sat_word(ACC_ONE);
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
      end
      op_ff    <= op_in;
      aux_ff   <= aux_in;
      rot_ff   <= rot_in;
      scale_ff <= scale_in;
      if (out_load) begin
         out_q_ff   <= q_ff;
         out_rot_ff <= rot_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quat_w    = out_q_ff[0];
   assign rsp_quat_x    = out_q_ff[1];
   assign rsp_quat_y    = out_q_ff[2];
   assign rsp_quat_z    = out_q_ff[3];
   assign rsp_rotated_x = out_rot_ff[0];
   assign rsp_rotated_y = out_rot_ff[1];
   assign rsp_rotated_z = out_rot_ff[2];

endmodule

FILE: hw/rtl/qou_lane.sv
// One multiply-accumulate lane: a registered product, then a floor shift
// and signed accumulation. Depends on qou_pkg for the lane control struct.
module qou_lane #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int ACC_WIDTH  = 67
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qou_pkg::lane_ctl_type         ctl_in,
   input  logic signed [WORD_WIDTH-1:0]  a_in,
   input  logic signed [WORD_WIDTH-1:0]  b_in,
   output logic signed [ACC_WIDTH-1:0]   acc_out
);
   import qou_pkg::*;

   lane_ctl_type                    ctl_ff;
   logic signed [2*WORD_WIDTH-1:0]  prod_ff;
   logic signed [ACC_WIDTH-1:0]     acc_ff;
   logic signed [ACC_WIDTH-1:0]     term;
   logic signed [ACC_WIDTH-1:0]     acc_in;

   always_comb begin
      term = ACC_WIDTH'(prod_ff >>> FRAC_BITS);
      if (ctl_ff.neg) begin
         term = -term;
      end
      acc_in = ctl_ff.first ? term : acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      prod_ff <= a_in * b_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

FILE: hw/rtl/qou_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on qou_pkg for the radicand and root widths.
module qou_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_in,
   input  logic [qou_pkg::RAD_W-1:0]   radicand_in,
   output logic                        done_out,
   output logic [qou_pkg::ROOT_W-1:0]  root_out
);
   import qou_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial  = REM_W'({root_ff, 2'b01});
      ge     = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start_in) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start_in) begin
         rad_ff  <= radicand_in;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_W'(ROOT_W - 1);
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done_out = done_ff;
   assign root_out = root_ff;

endmodule

FILE: hw/rtl/qou_div.sv
// Restoring unsigned divider, one quotient bit per cycle, one per lane.
// Self-contained; the top level supplies magnitudes and applies signs.
module qou_div #(
   parameter int DVD_WIDTH = 48,
   parameter int DSR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_in,
   input  logic [DVD_WIDTH-1:0]  dividend_in,
   input  logic [DSR_WIDTH-1:0]  divisor_in,
   output logic                  done_out,
   output logic [DVD_WIDTH-1:0]  quotient_out
);
   localparam int CNT_W = $clog2(DVD_WIDTH);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DVD_WIDTH-1:0] dvd_ff;
   logic [DVD_WIDTH-1:0] quo_ff;
   logic [DSR_WIDTH-1:0] dsr_ff;
   logic [DSR_WIDTH:0]   rem_ff;
   logic [DSR_WIDTH:0]   rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh = {rem_ff[DSR_WIDTH-1:0], dvd_ff[DVD_WIDTH-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start_in) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start_in) begin
         dvd_ff <= dividend_in;
         dsr_ff <= divisor_in;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= CNT_W'(DVD_WIDTH - 1);
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
         quo_ff <= {quo_ff[DVD_WIDTH-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done_out     = done_ff;
   assign quotient_out = quo_ff;

endmodule

FILE: test/quaternion_orientation_unit_core_checker.sv
// Checker for the quaternion orientation unit: watches both channels and the
// threshold write port, predicts each response and compares. Depends on qou_pkg.
module quaternion_orientation_unit_core_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [qou_pkg::KIND_W-1:0]  req_kind,
   input  logic signed [31:0]          req_operand_w,
   input  logic signed [31:0]          req_operand_x,
   input  logic signed [31:0]          req_operand_y,
   input  logic signed [31:0]          req_operand_z,
   input  logic signed [31:0]          req_scale,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [31:0]          rsp_quat_w,
   input  logic signed [31:0]          rsp_quat_x,
   input  logic signed [31:0]          rsp_quat_y,
   input  logic signed [31:0]          rsp_quat_z,
   input  logic signed [31:0]          rsp_rotated_x,
   input  logic signed [31:0]          rsp_rotated_y,
   input  logic signed [31:0]          rsp_rotated_z,
   input  logic                        csr_wr_en,
   input  logic [qou_pkg::EPS_W-1:0]   csr_wr_data,
   output int                          failures,
   output int                          outstanding
);
   import qou_pkg::*;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint UNITY = 64'sd65536;

   typedef struct {
      longint q[4];
      longint r[3];
   } orientation_result_type;

   longint attitude[4];
   longint threshold;
   orientation_result_type pending_results[$];

   function automatic longint clamp(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic void hamilton_product(input longint a[4], input longint b[4],
                                            output longint r[4]);
      r[0] = clamp(qmul(a[0], b[0]) - qmul(a[1], b[1]) - qmul(a[2], b[2]) - qmul(a[3], b[3]));
      r[1] = clamp(qmul(a[0], b[1]) + qmul(a[1], b[0]) + qmul(a[2], b[3]) - qmul(a[3], b[2]));
      r[2] = clamp(qmul(a[0], b[2]) + qmul(a[2], b[0]) + qmul(a[3], b[1]) - qmul(a[1], b[3]));
      r[3] = clamp(qmul(a[0], b[3]) + qmul(a[3], b[0]) + qmul(a[1], b[2]) - qmul(a[2], b[1]));
   endfunction

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void renormalize();
      logic [63:0] d;
      logic [63:0] s;
      d = 0;
      for (int i = 0; i < 4; i++) d = d + 64'(qmul(attitude[i], attitude[i]));
      if (d < 64'(threshold) || d == 0) begin
         attitude[0] = UNITY;
         return;
      end
      if (d > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) d = 64'hFFFF_FFFF_FFFF_FFFF >> 16;
      s = root64(d << 16);
      if (s == 0) begin
         attitude[0] = UNITY;
         return;
      end
      for (int i = 0; i < 4; i++) attitude[i] = clamp((attitude[i] * UNITY) / longint'(s));
   endfunction

   function automatic orientation_result_type apply_step(logic [2:0] kind, longint ow,
                                                         longint ox, longint oy, longint oz,
                                                         longint sc);
      orientation_result_type res;
      longint op[4];
      longint p[4];
      longint t[4];
      longint tw, tx, ty, tz, w, x, y, z;
      op = '{ow, ox, oy, oz};
      res.r = '{0, 0, 0};
      unique case (kind)
         KIND_LOAD: attitude = op;
         KIND_MUL: begin
            hamilton_product(attitude, op, t);
            attitude = t;
         end
         KIND_ROTV: begin
            op[0] = 0;
            hamilton_product(attitude, op, t);
            attitude = t;
         end
         KIND_ADDV: begin
            p[0] = 0;
            for (int i = 1; i < 4; i++) p[i] = clamp(qmul(op[i], sc));
            hamilton_product(p, attitude, t);
            for (int i = 0; i < 4; i++) attitude[i] = clamp(attitude[i] + (t[i] >>> 1));
         end
         KIND_NORM: renormalize();
         KIND_ROTINV: begin
            w = attitude[0]; x = attitude[1]; y = attitude[2]; z = attitude[3];
            tw = clamp(qmul(x, ox) + qmul(y, oy) + qmul(z, oz));
            tx = clamp(qmul(w, ox) - qmul(y, oz) + qmul(z, oy));
            ty = clamp(qmul(w, oy) - qmul(z, ox) + qmul(x, oz));
            tz = clamp(qmul(w, oz) - qmul(x, oy) + qmul(y, ox));
            res.r[0] = clamp(qmul(tw, x) + qmul(tx, w) + qmul(ty, z) - qmul(tz, y));
            res.r[1] = clamp(qmul(tw, y) - qmul(tx, z) + qmul(ty, w) + qmul(tz, x));
            res.r[2] = clamp(qmul(tw, z) + qmul(tx, y) - qmul(ty, x) + qmul(tz, w));
         end
         default: ;
      endcase
      res.q = attitude;
      return res;
   endfunction

   task automatic compare_field(string name, longint expected, logic signed [31:0] actual);
      if (longint'(actual) != expected) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      orientation_result_type want;
      if (reset) begin
         attitude = '{UNITY, 0, 0, 0};
         threshold = 1;
         pending_results.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) threshold = longint'(csr_wr_data);
         if (req_valid && req_ready)
            pending_results.push_back(apply_step(req_kind, req_operand_w, req_operand_x,
                                                 req_operand_y, req_operand_z, req_scale));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no prediction waiting");
               failures++;
            end else begin
               want = pending_results.pop_front();
               compare_field("quat_w", want.q[0], rsp_quat_w);
               compare_field("quat_x", want.q[1], rsp_quat_x);
               compare_field("quat_y", want.q[2], rsp_quat_y);
               compare_field("quat_z", want.q[3], rsp_quat_z);
               compare_field("rotated_x", want.r[0], rsp_rotated_x);
               compare_field("rotated_y", want.r[1], rsp_rotated_y);
               compare_field("rotated_z", want.r[2], rsp_rotated_z);
            end
         end
      end
      outstanding = pending_results.size();
   end
endmodule

FILE: test/quaternion_orientation_unit_core_test.sv
// Testbench top for the quaternion orientation unit: drives directed and random
// transactions and threshold writes. Depends on qou_pkg and the checker module.
module quaternion_orientation_unit_core_test;
   import qou_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_wr_en;
   logic [KIND_W-1:0] req_kind;
   logic signed [31:0] req_operand_w, req_operand_x, req_operand_y, req_operand_z, req_scale;
   logic signed [31:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic signed [31:0] rsp_rotated_x, rsp_rotated_y, rsp_rotated_z;
   logic [EPS_W-1:0] csr_wr_data;
   int failures, outstanding;
   bit calm, hold_off;

   quaternion_orientation_unit_core uut (.*);
   quaternion_orientation_unit_core_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0001_0000;
         3: return -32'sh0001_0000;
         4: return 32'(int'($urandom_range(0, 131072)) - 65536);
         5: return 32'(int'($urandom_range(0, 4194304)) - 2097152);
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic send(logic [2:0] kind, logic signed [31:0] w, x, y, z, s);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_operand_w <= w;
      req_operand_x <= x;
      req_operand_y <= y;
      req_operand_z <= z;
      req_scale <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_threshold(logic [EPS_W-1:0] value);
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic random_block(int count);
      for (int i = 0; i < count; i++)
         send(3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 5) : $urandom_range(6, 7)),
              pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
   endtask

   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_kind = KIND_LOAD;
      {req_operand_w, req_operand_x, req_operand_y, req_operand_z, req_scale} = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      calm = 0;
      hold_off = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(KIND_ROTINV, 0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      send(KIND_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      send(KIND_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      send(KIND_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send(KIND_ROTV, 0, 32'sh0000_8000, -32'sh0001_0000, 32'sh0002_0000, 0);
      send(KIND_ADDV, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
           32'sh8000_0000);
      send(KIND_ADDV, 0, 32'sh0000_1000, 32'sh0000_2000, -32'sh0000_1000, 32'sh0000_8000);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      send(KIND_ROTINV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send(3'd6, 1, 2, 3, 4, 5);
      send(3'd7, -1, -2, -3, -4, -5);
      send(KIND_LOAD, 0, 0, 0, 0, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      send(KIND_LOAD, 0, 32'sh0000_0001, 0, 0, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      write_threshold(17'd0);
      send(KIND_LOAD, 0, 0, 0, 0, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);
      send(KIND_LOAD, 0, 32'sh0000_0100, 0, 0, 0);
      send(KIND_NORM, 0, 0, 0, 0, 0);

      hold_off = 1;
      random_block(40);
      write_threshold(17'h10000);
      random_block(400);
      write_threshold(17'h1FFFF);
      random_block(300);
      write_threshold(17'($urandom_range(0, 65536)));
      random_block(450);
      calm = 1;
      random_block(200);
      req_valid <= 0;
      @(posedge clock);

      fork
         while (outstanding != 0) @(posedge clock);
         begin
            repeat (200000) @(posedge clock);
            $display("Mismatches found");
            $finish;
         end
      join_any
      disable fork;
      repeat (120) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
